// File: rtl/core/fdc_pkg.sv
// Shared types and constants for the frontier degree checker.
// No dependencies; used by fdc_deg_ram and frontier_degree_checker.
package fdc_pkg;

  localparam int VTX_W = 8;
  localparam int DEG_W = 2;
  localparam int CFG_IDX_W = 1;

  typedef logic [VTX_W-1:0] vtx_t;
  typedef logic [DEG_W-1:0] deg_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // item function codes
  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_ARC     = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t CFG_TERM_A = 1'b0;
  localparam cfg_idx_t CFG_TERM_B = 1'b1;

  localparam deg_t DEG_ZERO = 2'd0;
  localparam deg_t DEG_ONE  = 2'd1;
  localparam deg_t DEG_TWO  = 2'd2;
  localparam deg_t DEG_SAT  = 2'd3;

  // degree + 1, saturating at 3
  function automatic deg_t raise_deg(input deg_t d);
    raise_deg = (d == DEG_SAT) ? DEG_SAT : deg_t'(d + DEG_ONE);
  endfunction

endpackage

// File: rtl/core/fdc_deg_ram.sv
// Degree store: one write port, two registered read ports.
// Depends on fdc_pkg for the degree type.
module fdc_deg_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  fdc_pkg::deg_t   wdata,
  input  logic [AW-1:0]   raddr_a,
  input  logic [AW-1:0]   raddr_b,
  output fdc_pkg::deg_t   rdata_a,
  output fdc_pkg::deg_t   rdata_b
);
  import fdc_pkg::*;

  deg_t mem [DEPTH];
  deg_t rdata_a_r;
  deg_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: rtl/core/frontier_degree_checker.sv
// Frontier degree checker: top level, sequencer around the degree store.
// Depends on fdc_pkg and fdc_deg_ram.
//
// Usage:
//   Input channel: an item is taken when start is high and busy is low.
//   in_func selects a restart or an arc; the arc fields ride along.
//   Result channel: out_valid is high for one cycle with out_alive; the
//   receiver cannot stall, so every result is taken in the cycle it shows.
//   Config channel: cfg_ready is always high; cfg_index 0 writes
//   terminal_a, 1 writes terminal_b. Write only while the block is idle.
// Sequencing (out_valid is registered as the item leaves the last state named):
//   restart, arc while pruned, arc beyond the store: answered from idle, busy stays low.
//   arc not taken, or taken and pruned at the check: read, then evaluate.
//   taken arc that survives: read, evaluate, then the high-endpoint write. A taken arc
//   that reaches new vertices first walks the init state over each newly reached vertex.
//   The two store writes for the endpoints share the single write port, so they
//   fall in separate states: evaluate, then the high-endpoint write.
// Reset: terminals clear to 0, no vertex seen, not pruned. The store holds
//   no reset value; entries are initialized by the walk before a read of them is used.
module frontier_degree_checker #(
  parameter int VERTICES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  fdc_pkg::vtx_t        in_low_vertex,
  input  fdc_pkg::vtx_t        in_high_vertex,
  input  logic                 in_take,
  input  logic                 in_low_last,
  input  logic                 in_high_last,
  output logic                 out_valid,
  output logic                 out_alive,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  fdc_pkg::cfg_idx_t    cfg_index,
  input  fdc_pkg::vtx_t        cfg_data
);
  import fdc_pkg::*;

  localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam logic [16:0] VLIMIT = 17'(VERTICES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_WRH  = 3'd4;

  logic [2:0] state_r, state_nxt;
  vtx_t       term_a_r, term_a_nxt;
  vtx_t       term_b_r, term_b_nxt;
  logic       seen_r, seen_nxt;
  vtx_t       hs_r, hs_nxt;
  logic       pruned_r, pruned_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_alive_r, out_alive_nxt;
  vtx_t       lv_r, lv_nxt;
  vtx_t       hv_r, hv_nxt;
  logic       take_r, take_nxt;
  logic       llast_r, llast_nxt;
  logic       hlast_r, hlast_nxt;
  vtx_t       ptr_r, ptr_nxt;
  deg_t       nh_r, nh_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  deg_t          wdata;
  deg_t          rd_lo, rd_hi;

  // accept-side decode
  logic accept;
  logic swap;
  vtx_t lo_sel, hi_sel;
  logic llast_sel, hlast_sel;
  logic out_of_range;
  logic hi_reached;

  // evaluate-side decode
  deg_t nl, dh, nh, lo_after, hi_after;
  logic lo_reach, hi_reach, raise_fail, lfail, hfail, eval_fail;

  function automatic logic is_term(input vtx_t v, input vtx_t ta, input vtx_t tb);
    is_term = (v == ta) || (v == tb);
  endfunction

  fdc_deg_ram #(
    .DEPTH (VERTICES),
    .AW    (AW)
  ) u_deg_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (AW'(lv_r)),
    .raddr_b (AW'(hv_r)),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_alive = out_alive_r;
  assign accept    = start && !busy;

  always_comb begin
    swap         = in_low_vertex > in_high_vertex;
    lo_sel       = swap ? in_high_vertex : in_low_vertex;
    hi_sel       = swap ? in_low_vertex : in_high_vertex;
    llast_sel    = swap ? in_high_last : in_low_last;
    hlast_sel    = swap ? in_low_last : in_high_last;
    out_of_range = (17'(lo_sel) >= VLIMIT) || (17'(hi_sel) >= VLIMIT);
    hi_reached   = seen_r && (hi_sel <= hs_r);
  end

  always_comb begin
    nl = raise_deg(rd_lo);
    dh = (lv_r == hv_r) ? nl : rd_hi;
    nh = raise_deg(dh);
    if (take_r) begin
      raise_fail = (nl > DEG_TWO) || (nh > DEG_TWO);
      lo_after   = (lv_r == hv_r) ? nh : nl;
      hi_after   = nh;
    end else begin
      raise_fail = 1'b0;
      lo_after   = rd_lo;
      hi_after   = rd_hi;
    end
    lo_reach  = seen_r && (lv_r <= hs_r);
    hi_reach  = seen_r && (hv_r <= hs_r);
    lfail     = llast_r &&
                (lo_reach ? (lo_after == DEG_ONE) : is_term(lv_r, term_a_r, term_b_r));
    hfail     = hlast_r &&
                (hi_reach ? (hi_after == DEG_ONE) : is_term(hv_r, term_a_r, term_b_r));
    eval_fail = raise_fail || lfail || hfail;
  end

  always_comb begin
    state_nxt     = state_r;
    term_a_nxt    = term_a_r;
    term_b_nxt    = term_b_r;
    seen_nxt      = seen_r;
    hs_nxt        = hs_r;
    pruned_nxt    = pruned_r;
    out_valid_nxt = 1'b0;
    out_alive_nxt = out_alive_r;
    lv_nxt        = lv_r;
    hv_nxt        = hv_r;
    take_nxt      = take_r;
    llast_nxt     = llast_r;
    hlast_nxt     = hlast_r;
    ptr_nxt       = ptr_r;
    nh_nxt        = nh_r;
    we            = 1'b0;
    waddr         = AW'(ptr_r);
    wdata         = DEG_ZERO;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TERM_A: term_a_nxt = cfg_data;
        CFG_TERM_B: term_b_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          lv_nxt    = lo_sel;
          hv_nxt    = hi_sel;
          take_nxt  = in_take;
          llast_nxt = llast_sel;
          hlast_nxt = hlast_sel;
          if (in_func == FUNC_RESTART) begin
            seen_nxt      = 1'b0;
            hs_nxt        = '0;
            pruned_nxt    = 1'b0;
            out_valid_nxt = 1'b1;
            out_alive_nxt = 1'b1;
          end else if (pruned_r) begin
            out_valid_nxt = 1'b1;
            out_alive_nxt = 1'b0;
          end else if (out_of_range) begin
            pruned_nxt    = 1'b1;
            out_valid_nxt = 1'b1;
            out_alive_nxt = 1'b0;
          end else if (in_take && !hi_reached) begin
            // walk newly reached vertices up to the high endpoint
            ptr_nxt   = seen_r ? vtx_t'(hs_r + 1'b1) : '0;
            hs_nxt    = hi_sel;
            seen_nxt  = 1'b1;
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_INIT: begin
        we    = 1'b1;
        waddr = AW'(ptr_r);
        wdata = is_term(ptr_r, term_a_r, term_b_r) ? DEG_ONE : DEG_ZERO;
        if (ptr_r == hv_r) begin
          state_nxt = ST_READ;
        end else begin
          ptr_nxt = vtx_t'(ptr_r + 1'b1);
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        // after a prune the store contents no longer matter
        we     = take_r;
        waddr  = AW'(lv_r);
        wdata  = nl;
        nh_nxt = nh;
        if (take_r && !eval_fail) begin
          state_nxt = ST_WRH;
        end else begin
          pruned_nxt    = eval_fail;
          out_valid_nxt = 1'b1;
          out_alive_nxt = !eval_fail;
          state_nxt     = ST_IDLE;
        end
      end
      ST_WRH: begin
        we            = 1'b1;
        waddr         = AW'(hv_r);
        wdata         = nh_r;
        out_valid_nxt = 1'b1;
        out_alive_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      term_a_r    <= '0;
      term_b_r    <= '0;
      seen_r      <= 1'b0;
      hs_r        <= '0;
      pruned_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_alive_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      term_a_r    <= term_a_nxt;
      term_b_r    <= term_b_nxt;
      seen_r      <= seen_nxt;
      hs_r        <= hs_nxt;
      pruned_r    <= pruned_nxt;
      out_valid_r <= out_valid_nxt;
      out_alive_r <= out_alive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r    <= lv_nxt;
    hv_r    <= hv_nxt;
    take_r  <= take_nxt;
    llast_r <= llast_nxt;
    hlast_r <= hlast_nxt;
    ptr_r   <= ptr_nxt;
    nh_r    <= nh_nxt;
  end

  // result always mirrors the sticky prune flag
  a_alive_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_alive_r == !pruned_r))
    else $error("out_alive disagrees with prune flag");

  a_restart_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_RESTART) |=> (out_valid_r && out_alive_r && !seen_r))
    else $error("restart did not report alive");

  a_init_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> (ptr_r <= hv_r && seen_r && hs_r == hv_r))
    else $error("init walk past high endpoint");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_READ) |-> !we)
    else $error("store write outside a write state");

endmodule

// File: dv/tb_top.sv
// Testbench for frontier_degree_checker: directed and random arc items, checked against a
// built-in degree tracker. Depends on fdc_pkg and the frontier_degree_checker RTL.
`timescale 1ns / 100ps

module tb_top;
  import fdc_pkg::*;

  localparam int NUM_VTX = 256;

  typedef struct packed {
    logic func;
    vtx_t lo_v;
    vtx_t hi_v;
    logic take;
    logic lo_last;
    logic hi_last;
  } arc_item_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  logic     in_func = FUNC_RESTART;
  vtx_t     in_low_vertex = '0;
  vtx_t     in_high_vertex = '0;
  logic     in_take = 1'b0;
  logic     in_low_last = 1'b0;
  logic     in_high_last = 1'b0;
  logic     out_valid;
  logic     out_alive;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_TERM_A;
  vtx_t     cfg_data = '0;

  frontier_degree_checker i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_low_vertex (in_low_vertex),
    .in_high_vertex(in_high_vertex),
    .in_take       (in_take),
    .in_low_last   (in_low_last),
    .in_high_last  (in_high_last),
    .out_valid     (out_valid),
    .out_alive     (out_alive),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // degree tracker state
  deg_t deg_mem [NUM_VTX];
  logic seen_any = 1'b0;
  int   top_seen = 0;
  logic pruned = 1'b0;
  vtx_t term_a = '0;
  vtx_t term_b = '0;

  arc_item_t pend_q [$];
  logic      alive_exp_q [$];
  arc_item_t cur_item;
  int        idle_pct = 0;
  int        fail_cnt = 0;
  int        res_cnt = 0;

  function automatic logic is_term(int v);
    return v == term_a || v == term_b;
  endfunction

  function automatic logic reached(int v);
    return seen_any && v <= top_seen;
  endfunction

  // raise a degree, saturating; 1 when it went past two
  function automatic logic bump_deg(int v);
    if (deg_mem[v] != DEG_SAT) deg_mem[v] = deg_t'(deg_mem[v] + 2'd1);
    return deg_mem[v] == DEG_SAT;
  endfunction

  function automatic logic last_bad(int v);
    if (reached(v)) return deg_mem[v] == DEG_ONE;
    return is_term(v);
  endfunction

  function automatic logic track_degrees(arc_item_t it);
    vtx_t lv;
    vtx_t hv;
    logic ll;
    logic hl;
    logic fail;
    if (it.func == FUNC_RESTART) begin
      seen_any = 1'b0;
      top_seen = 0;
      pruned = 1'b0;
    end else if (!pruned) begin
      lv = it.lo_v;
      hv = it.hi_v;
      ll = it.lo_last;
      hl = it.hi_last;
      if (lv > hv) begin
        lv = it.hi_v;
        hv = it.lo_v;
        ll = it.hi_last;
        hl = it.lo_last;
      end
      fail = (int'(hv) >= NUM_VTX);
      if (!fail && it.take) begin
        if (!reached(hv)) begin
          // newly reached vertices enter at 0, terminals at 1
          for (int v = seen_any ? top_seen + 1 : 0; v <= hv; v++)
            deg_mem[v] = is_term(v) ? DEG_ONE : DEG_ZERO;
          top_seen = hv;
          seen_any = 1'b1;
        end
        fail = bump_deg(lv);
        if (!fail) fail = bump_deg(hv);
      end
      if (!fail && ll) fail = last_bad(lv);
      if (!fail && hl) fail = last_bad(hv);
      if (fail) pruned = 1'b1;
    end
    return !pruned;
  endfunction

  function automatic void queue_item(logic f, vtx_t lo, vtx_t hi, logic tk, logic ll,
                                     logic hl);
    arc_item_t it;
    it.func = f;
    it.lo_v = lo;
    it.hi_v = hi;
    it.take = tk;
    it.lo_last = ll;
    it.hi_last = hl;
    pend_q.push_back(it);
  endfunction

  // restart, then the arcs of a small random graph in order, last-arc flags set correctly
  task automatic queue_graph();
    bit        used [NUM_VTX];
    bit        done [NUM_VTX];
    vtx_t      vset [$];
    arc_item_t arcs [$];
    arc_item_t a;
    vtx_t      tmp;
    int        n;
    int        cnt;
    int        v;
    int        keep;
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(2, 7);
    cnt = 0;
    if ($urandom_range(4) != 0) begin
      used[term_a] = 1'b1;
      cnt++;
    end
    if ($urandom_range(4) != 0 && !used[term_b]) begin
      used[term_b] = 1'b1;
      cnt++;
    end
    while (cnt < n) begin
      v = $urandom_range(NUM_VTX - 1);
      if (!used[v]) begin
        used[v] = 1'b1;
        cnt++;
      end
    end
    for (int i = 0; i < NUM_VTX; i++)
      if (used[i]) vset.push_back(vtx_t'(i));
    for (int i = 0; i < vset.size(); i++)
      for (int j = i + 1; j < vset.size(); j++)
        if (j == i + 1 || $urandom_range(2) == 0) begin
          a.func = FUNC_ARC;
          a.lo_v = vset[i];
          a.hi_v = vset[j];
          a.take = ($urandom_range(99) < 45);
          a.lo_last = 1'b0;
          a.hi_last = 1'b0;
          arcs.push_back(a);
        end
    for (int k = arcs.size() - 1; k >= 0; k--) begin
      if (!done[arcs[k].lo_v]) begin
        arcs[k].lo_last = 1'b1;
        done[arcs[k].lo_v] = 1'b1;
      end
      if (!done[arcs[k].hi_v]) begin
        arcs[k].hi_last = 1'b1;
        done[arcs[k].hi_v] = 1'b1;
      end
    end
    // some sequences are cut short
    keep = ($urandom_range(9) == 0) ? (arcs.size() + 1) / 2 : arcs.size();
    queue_item(FUNC_RESTART, vtx_t'($urandom_range(255)), vtx_t'($urandom_range(255)),
               1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    for (int k = 0; k < keep; k++) begin
      a = arcs[k];
      if ($urandom_range(9) == 0) begin
        tmp = a.lo_v;
        a.lo_v = a.hi_v;
        a.hi_v = tmp;
        {a.lo_last, a.hi_last} = {a.hi_last, a.lo_last};
      end
      pend_q.push_back(a);
    end
  endtask

  task automatic write_terminal(cfg_idx_t idx, vtx_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TERM_A) term_a = val;
    else term_b = val;
  endtask

  // driver: one item on the ports at a time, held until taken
  always @(posedge clk) begin : drive_p
    logic go;
    go = start;
    if (!rst_n) begin
      go = 1'b0;
    end else begin
      if (start && !busy) begin
        alive_exp_q.push_back(track_degrees(cur_item));
        go = 1'b0;
      end
      if (!go && pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur_item = pend_q.pop_front();
        in_func <= cur_item.func;
        in_low_vertex <= cur_item.lo_v;
        in_high_vertex <= cur_item.hi_v;
        in_take <= cur_item.take;
        in_low_last <= cur_item.lo_last;
        in_high_last <= cur_item.hi_last;
        go = 1'b1;
      end
    end
    start <= go;
  end

  always @(posedge clk) begin : monitor_p
    logic exp_alive;
    if (rst_n && out_valid) begin
      res_cnt++;
      if (alive_exp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("result %0d with no item pending: alive=%b", res_cnt, out_alive);
      end else begin
        exp_alive = alive_exp_q.pop_front();
        if (out_alive !== exp_alive) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d: alive expected %b, got %b", res_cnt, exp_alive, out_alive);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stim_p
    vtx_t ta;
    vtx_t tb;
    int   goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 38 : (ph < 4) ? 69 : 0;
      case (ph)
        0: begin ta = 8'd3; tb = 8'd7; end
        1: begin ta = 8'd0; tb = 8'd255; end
        2: begin ta = 8'd255; tb = 8'd0; end
        3: begin ta = 8'd5; tb = 8'd5; end
        4: begin ta = vtx_t'($urandom_range(255)); tb = vtx_t'($urandom_range(255)); end
        default: begin ta = 8'd0; tb = 8'd0; end
      endcase
      write_terminal(CFG_TERM_A, ta);
      write_terminal(CFG_TERM_B, tb);
      if (ph == 0) begin
        // terminals are 3 and 7 here
        queue_item(FUNC_RESTART, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_item(FUNC_ARC, 8'd0, 8'd1, 1'b0, 1'b1, 1'b1);    // unreached plain vertices
        queue_item(FUNC_ARC, 8'd3, 8'd7, 1'b1, 1'b0, 1'b0);
        queue_item(FUNC_ARC, 8'd7, 8'd3, 1'b1, 1'b0, 1'b0);    // swapped, degree 3
        queue_item(FUNC_ARC, 8'd0, 8'd1, 1'b1, 1'b0, 1'b0);    // while pruned
        queue_item(FUNC_RESTART, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
        queue_item(FUNC_ARC, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1); // full walk, self loop
        queue_item(FUNC_ARC, 8'd0, 8'd255, 1'b0, 1'b1, 1'b1);
        queue_item(FUNC_RESTART, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_item(FUNC_ARC, 8'd0, 8'd3, 1'b0, 1'b0, 1'b1);    // terminal never reached
        queue_item(FUNC_RESTART, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_item(FUNC_ARC, 8'd1, 8'd2, 1'b1, 1'b1, 1'b0);    // dangling end
        queue_item(FUNC_RESTART, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_item(FUNC_ARC, 8'd3, 8'd5, 1'b1, 1'b1, 1'b0);
        queue_item(FUNC_ARC, 8'd5, 8'd7, 1'b1, 1'b1, 1'b1);
        queue_item(FUNC_ARC, 8'd4, 8'd6, 1'b0, 1'b1, 1'b1);
        queue_item(FUNC_RESTART, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_item(FUNC_ARC, 8'd4, 8'd4, 1'b1, 1'b0, 1'b0);
        queue_item(FUNC_ARC, 8'd2, 8'd4, 1'b1, 1'b0, 1'b0);
        queue_item(FUNC_RESTART, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        queue_item(FUNC_ARC, 8'd6, 8'd2, 1'b1, 1'b0, 1'b1);    // flags follow the swap
        queue_item(FUNC_RESTART, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      end
      goal = pend_q.size() + 62;
      while (pend_q.size() < goal) begin
        if ($urandom_range(99) < 15)
          queue_item(1'($urandom_range(1)), vtx_t'($urandom_range(255)),
                     vtx_t'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          queue_graph();
      end
      while (pend_q.size() > 0 || start || alive_exp_q.size() > 0) @(posedge clk);
      repeat (8) @(posedge clk);
      while (busy) @(posedge clk);
    end
    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && alive_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/fdc_pkg.sv
rtl/core/fdc_deg_ram.sv
rtl/core/frontier_degree_checker.sv
dv/tb_top.sv
